// ----- hw/rtl/float_to_decimal_ascii_defines.svh -----
// Assertion macros shared by the float-to-decimal text converter.
`ifndef FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH
`define FLOAT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FDA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/fda_pkg.sv -----
// Shared constants, types and functions of the float-to-decimal text converter.
`default_nettype none
package fda_pkg;
   localparam int BIN_W    = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int MAX_FRAC = 9;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [7:0] EXP_LIMIT = 8'd158;
   localparam logic [7:0] EXP_UNIT  = 8'd150;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_stat_type;

   function automatic logic [29:0] pow_ten(input logic [3:0] n);
      logic [29:0] r;
      unique case (n)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         default: r = 30'd1000000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/fda_bcd.sv -----
// Iterative binary to packed decimal converter, one shift-and-adjust step per cycle.
`default_nettype none
module fda_bcd (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fda_pkg::BIN_W-1:0]  bin,
   output fda_pkg::bcd_stat_type           stat,
   output logic      [fda_pkg::BCD_W-1:0]  bcd
);
   import fda_pkg::*;

   logic [BIN_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in, adj;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? 4'(bcd_ff[i*4 +: 4] + 4'd3)
                                                    : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = bin;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in = {bin_ff[BIN_W-2:0], 1'b0};
         cnt_in = 5'(cnt_ff + 5'd1);
         if (cnt_ff == 5'(BIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/float_to_decimal_ascii.sv -----
// Top level of the single-precision float to fixed-digit decimal text converter.
//
//   channel | direction | contents
//   req_    | in        | tdata: value_bits [31:0], frac_digits [35:32]
//   rsp_    | out       | tdata: character; tlast: last_char; tuser: range_error
//
// An out-of-range request is split and answered with a lone error character. Any other
// request runs through a split, one multiply, a normalizing shift, a rounding step, and a
// decimal conversion in the shared converter for the integer part and, when fraction digits
// are asked for, the fraction part. Characters leave one per cycle while rsp_tready holds.
// req_tready is high only while no request is in work. Reset is synchronous.
`default_nettype none
module float_to_decimal_ascii (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value_bits [31:0], frac_digits [35:32], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // character [7:0]
   output logic             rsp_tlast,
   output logic             rsp_tuser    // range_error [0]
);
   import fda_pkg::*;
   `include "float_to_decimal_ascii_defines.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_SPLIT, S_MUL, S_NORM, S_ROUND, S_ICONV, S_IWAIT, S_SIGN,
      S_IDIG, S_DOT, S_FCONV, S_FWAIT, S_FDIG, S_ERR
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  val_ff, val_in;
   logic [3:0]   fd_ff, fd_in;
   logic         neg_ff, neg_in;
   logic [31:0]  imag_ff, imag_in;
   logic [23:0]  frac_ff, frac_in;
   logic [7:0]   k_ff, k_in;
   logic [53:0]  prod_ff, prod_in;
   logic [5:0]   z_ff, z_in;
   logic [31:0]  fmag_ff, fmag_in;
   logic [3:0]   idx_ff, idx_in;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]   rsp_char_ff, rsp_char_in;
   logic         rsp_last_ff, rsp_last_in, rsp_err_ff, rsp_err_in;

   logic [7:0]   expo, eff, kk;
   logic [23:0]  m24;
   logic         out_free, rup;
   logic [24:0]  rnd;
   logic signed [9:0] sh;
   logic [9:0]   lsh;
   logic [3:0]   msd, fmin, nib;
   logic         bcd_start;
   logic [BIN_W-1:0] bcd_bin;
   logic [BCD_W-1:0] bcd_val;
   bcd_stat_type bcd_stat;

   assign expo     = val_ff[30:23];
   assign eff      = (expo == 8'd0) ? 8'd1 : expo;
   assign kk       = 8'(EXP_UNIT - eff);
   assign m24      = {|expo, val_ff[22:0]};
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign rup      = prod_ff[29] && ((|prod_ff[28:0]) || prod_ff[30]);
   assign rnd      = 25'({1'b0, prod_ff[53:30]} + 25'(rup));
   assign sh       = $signed({2'b00, k_ff}) + $signed({4'b0000, z_ff}) - 10'sd30;
   assign lsh      = 10'(-sh);
   assign fmin     = 4'(fd_ff - 4'd1);
   assign nib      = bcd_val[idx_ff*4 +: 4];
   assign bcd_bin  = (state_ff == S_ICONV) ? imag_ff : fmag_ff;

   always_comb begin
      msd = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_val[i*4 +: 4] != 4'd0) msd = 4'(i);
      end
   end

   fda_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (bcd_bin),
      .stat  (bcd_stat),
      .bcd   (bcd_val)
   );

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      fd_in         = fd_ff;
      neg_in        = neg_ff;
      imag_in       = imag_ff;
      frac_in       = frac_ff;
      k_in          = k_ff;
      prod_in       = prod_ff;
      z_in          = z_ff;
      fmag_in       = fmag_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      bcd_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in   = req_tdata[31:0];
               fd_in    = (req_tdata[35:32] > 4'(MAX_FRAC)) ? 4'(MAX_FRAC) : req_tdata[35:32];
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            neg_in = val_ff[31] && (|val_ff[30:0]);
            if (expo >= EXP_LIMIT) begin
               state_in = S_ERR;
            end else begin
               if (eff >= EXP_UNIT) begin
                  imag_in = 32'(m24) << 3'(eff - EXP_UNIT);
                  frac_in = '0;
                  k_in    = '0;
               end else if (kk >= 8'd24) begin
                  imag_in = '0;
                  frac_in = m24;
                  k_in    = kk;
               end else begin
                  imag_in = 32'(m24 >> kk[4:0]);
                  frac_in = m24 & ~(24'hFFFFFF << kk[4:0]);
                  k_in    = kk;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = frac_ff * pow_ten(fd_ff);
            z_in     = '0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (prod_ff == '0) begin
               fmag_in  = '0;
               state_in = S_ICONV;
            end else if (prod_ff[53]) begin
               state_in = S_ROUND;
            end else begin
               prod_in = {prod_ff[52:0], 1'b0};
               z_in    = 6'(z_ff + 6'd1);
            end
         end
         S_ROUND: begin
            if (sh < 0) begin
               fmag_in = 32'(rnd) << lsh[4:0];
            end else if (sh >= 10'sd25) begin
               fmag_in = '0;
            end else begin
               fmag_in = 32'(rnd >> sh[4:0]);
            end
            state_in = S_ICONV;
         end
         S_ICONV: begin
            bcd_start = 1'b1;
            state_in  = S_IWAIT;
         end
         S_IWAIT: begin
            if (bcd_stat.done) begin
               idx_in   = msd;
               state_in = neg_ff ? S_SIGN : S_IDIG;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CHAR_MINUS;
               rsp_last_in   = 1'b0;
               rsp_err_in    = 1'b0;
               state_in      = S_IDIG;
            end
         end
         S_IDIG: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = 8'(CHAR_ZERO + 8'(nib));
               rsp_last_in   = (idx_ff == 4'd0) && (fd_ff == 4'd0);
               rsp_err_in    = 1'b0;
               if (idx_ff == 4'd0) begin
                  state_in = (fd_ff == 4'd0) ? S_IDLE : S_DOT;
               end else begin
                  idx_in = 4'(idx_ff - 4'd1);
               end
            end
         end
         S_DOT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CHAR_DOT;
               rsp_last_in   = 1'b0;
               rsp_err_in    = 1'b0;
               state_in      = S_FCONV;
            end
         end
         S_FCONV: begin
            bcd_start = 1'b1;
            state_in  = S_FWAIT;
         end
         S_FWAIT: begin
            if (bcd_stat.done) begin
               idx_in   = (msd > fmin) ? msd : fmin;
               state_in = S_FDIG;
            end
         end
         S_FDIG: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = 8'(CHAR_ZERO + 8'(nib));
               rsp_last_in   = (idx_ff == 4'd0);
               rsp_err_in    = 1'b0;
               if (idx_ff == 4'd0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = 4'(idx_ff - 4'd1);
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CHAR_NUL;
               rsp_last_in   = 1'b1;
               rsp_err_in    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      fd_ff       <= fd_in;
      neg_ff      <= neg_in;
      imag_ff     <= imag_in;
      frac_ff     <= frac_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      z_ff        <= z_in;
      fmag_ff     <= fmag_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   `FDA_ASSERT_IMP(a_err_single, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_tdata == CHAR_NUL, "error result must be a lone NUL character")
   `FDA_ASSERT_NXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "request accepted while a conversion is starting")
   `FDA_ASSERT_IMP(a_bcd_wait, bcd_stat.busy, state_ff == S_IWAIT || state_ff == S_FWAIT, "decimal converter busy outside a wait state")
endmodule
`default_nettype wire
